/* rtl/sdf_pkg.sv */
// Shared types, constants and the double-dabble step function for the decimal formatter.
package sdf_pkg;

  localparam int BIN_W           = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int DD_W            = BCD_W + BIN_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_DD_STAGES   = BIN_W / STEPS_PER_STAGE;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  typedef logic [DD_W-1:0]  dd_word_t;   // {bcd, remaining binary}
  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [3:0]       digit_t;
  typedef logic [3:0]       count_t;

  // Several shift-add-3 steps of the binary to BCD conversion.
  function automatic dd_word_t dd_steps(input dd_word_t w);
    dd_word_t v;
    v = w;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (v[BIN_W + 4*d +: 4] >= 4'd5) begin
          v[BIN_W + 4*d +: 4] = v[BIN_W + 4*d +: 4] + 4'd3;
        end
      end
      v = v << 1;
    end
    return v;
  endfunction

endpackage

/* rtl/signed_decimal_formatter_unit.sv */
// Top level: signed 32-bit integer to decimal ASCII text, one character per transaction.
//
//  channel | direction | tdata (low bit up)                        | tlast
//  --------+-----------+-------------------------------------------+-----------------
//  in_     | slave     | value[31:0]                               | -
//  out_    | master    | char_code[5:0], text_length[9:6], pad     | last_char
//
// Stages: conversion is 1 capture stage plus 8 double-dabble stages of 4 steps each, then
// the output register, which drives out_tvalid and out_tdata.
// The output register sends a number's text (1 to 11 characters) one character per cycle
// while out_tready is high; the next number loads on the same edge that the last
// character leaves.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// Stalls: out_tready low holds the current character; the pipeline keeps filling until
// each stage holds a number, then in_tready drops. Nothing is lost or repeated.
module signed_decimal_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value (signed)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [5:0] char_code, [9:6] text_length, [15:10] zero
  output logic        out_tlast    // last_char
);

  localparam int LAST = sdf_pkg::NUM_DD_STAGES;   // index of final conversion stage

  // conversion pipeline: stage 0 captures sign and magnitude, stages 1..LAST dabble
  logic                 valid_r [LAST+1];
  logic                 neg_r   [LAST+1];
  sdf_pkg::dd_word_t    word_r  [LAST+1];
  logic                 take    [LAST+1];

  // output serializer
  logic                 ser_valid_r;
  logic                 ser_neg_r;      // minus sign still to be sent
  sdf_pkg::count_t      ser_idx_r;      // digit currently shown
  sdf_pkg::count_t      ser_total_r;
  sdf_pkg::digit_t      ser_digits_r [sdf_pkg::NUM_DIGITS];

  logic                 ser_free;
  logic                 out_hs;
  logic [31:0]          mag;
  sdf_pkg::bcd_t        fin_bcd;
  sdf_pkg::count_t      fin_nd;
  logic [5:0]           char_code;
  sdf_pkg::count_t      text_length;

  assign out_hs   = out_tvalid && out_tready;
  assign ser_free = !ser_valid_r || (out_hs && out_tlast);

  // ready ripples back: a stage takes new data when empty or when it moves on
  always_comb begin
    take[LAST] = !valid_r[LAST] || ser_free;
    for (int i = LAST - 1; i >= 0; i--) begin
      take[i] = !valid_r[i] || take[i+1];
    end
  end

  assign in_tready = take[0];

  // two's complement magnitude; the most negative value wraps to 2^31 as unsigned
  assign mag = in_tdata[31] ? (~in_tdata + 32'd1) : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (take[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (take[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      neg_r[0]  <= in_tdata[31];
      word_r[0] <= {{sdf_pkg::BCD_W{1'b0}}, mag};
    end
    for (int i = 1; i <= LAST; i++) begin
      if (take[i]) begin
        neg_r[i]  <= neg_r[i-1];
        word_r[i] <= sdf_pkg::dd_steps(word_r[i-1]);
      end
    end
  end

  // digit count of the finished BCD word: position of the top nonzero digit, at least one
  assign fin_bcd = word_r[LAST][sdf_pkg::DD_W-1 -: sdf_pkg::BCD_W];

  always_comb begin
    fin_nd = 4'd1;
    for (int d = 1; d < sdf_pkg::NUM_DIGITS; d++) begin
      if (fin_bcd[4*d +: 4] != 4'd0) begin
        fin_nd = 4'(d + 1);
      end
    end
  end

  // serializer: minus first if negative, then digits from the top one down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
    end else if (ser_free) begin
      ser_valid_r <= valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      ser_neg_r   <= neg_r[LAST];
      ser_idx_r   <= fin_nd - 4'd1;
      ser_total_r <= fin_nd + {3'd0, neg_r[LAST]};
      for (int d = 0; d < sdf_pkg::NUM_DIGITS; d++) begin
        ser_digits_r[d] <= fin_bcd[4*d +: 4];
      end
    end else if (out_hs) begin
      if (ser_neg_r) begin
        ser_neg_r <= 1'b0;
      end else begin
        ser_idx_r <= ser_idx_r - 4'd1;
      end
    end
  end

  always_comb begin
    out_tlast   = !ser_neg_r && (ser_idx_r == 4'd0);
    char_code   = ser_neg_r ? sdf_pkg::CHAR_MINUS
                            : sdf_pkg::CHAR_ZERO + {2'd0, ser_digits_r[ser_idx_r]};
    text_length = out_tlast ? ser_total_r : 4'd0;
  end

  assign out_tvalid = ser_valid_r;
  assign out_tdata  = {6'd0, text_length, char_code};

endmodule

/* tb/sv/signed_decimal_formatter_unit_tb.sv */
// Self-checking testbench for the signed 32-bit integer to decimal ASCII text formatter.
module signed_decimal_formatter_unit_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_VALUES = 207;
  localparam int HOLD_OFF_LEN  = 400;   // long receiver stall, fills the pipeline
  localparam int HOLD_OFF_AT   = 150;   // input transactions before the stall starts
  localparam int QUIET_FROM    = 60;    // stretch with no idling on either side
  localparam int QUIET_TO      = 110;
  localparam int IDLE_PCT      = 15;
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES  = 30;    // pipeline depth plus a margin
  localparam int PRINT_CAP     = 30;

  // one character of formatted text, as the output channel carries it
  typedef struct packed {
    logic [5:0]       char_code;
    logic             last_char;
    sdf_pkg::count_t  text_length;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  logic [31:0] pending_values[$];
  text_char_t  expected_chars[$];

  logic        in_taken = 1'b0;
  int          values_accepted = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;
  int          chars_checked = 0;
  int          numbers_done = 0;
  int          negatives_sent = 0;
  logic [11:0] lengths_seen = '0;

  wire quiet_stretch = (values_accepted >= QUIET_FROM) && (values_accepted < QUIET_TO);

  signed_decimal_formatter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Text predictor: magnitude in 32-bit unsigned arithmetic, so the most
  // negative value falls out like any other negative number.
  // ---------------------------------------------------------------------------
  function automatic void predict_text(input logic [31:0] raw);
    logic             neg;
    logic [31:0]      mag;
    sdf_pkg::digit_t  digs[10];
    int               nd;
    int               total;
    text_char_t       c;
    neg = raw[31];
    mag = neg ? (~raw + 32'd1) : raw;
    nd = 0;
    do begin
      digs[nd] = sdf_pkg::digit_t'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 0 && nd < sdf_pkg::NUM_DIGITS);
    total = nd + (neg ? 1 : 0);
    if (neg) begin
      c.char_code   = sdf_pkg::CHAR_MINUS;
      c.last_char   = (total == 1);
      c.text_length = (total == 1) ? sdf_pkg::count_t'(total) : '0;
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.char_code   = sdf_pkg::CHAR_ZERO + 6'(digs[i]);
      c.last_char   = (i == 0);
      c.text_length = (i == 0) ? sdf_pkg::count_t'(total) : '0;
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [31:0] ten_pow(input int k);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < k; i++) p = p * 32'd10;
    return p;
  endfunction

  // Mix of full-range words, short numbers and values at or just below a power of ten.
  function automatic logic [31:0] random_value();
    logic [31:0] m;
    case ($urandom_range(3))
      0, 1: m = $urandom;
      2: m = $urandom_range(ten_pow($urandom_range(1, 9)) - 1);
      default: m = ten_pow($urandom_range(9)) - $urandom_range(1);
    endcase
    if ($urandom_range(1) == 1) m = ~m + 32'd1;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic check_char(input logic [15:0] data, input logic tlast);
    text_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("character with nothing expected, code", data[5:0], 0);
    end else begin
      want = expected_chars.pop_front();
      if (data[5:0] !== want.char_code)
        report_mismatch("char_code", data[5:0], want.char_code);
      if (tlast !== want.last_char)
        report_mismatch("last_char", tlast, want.last_char);
      if (data[9:6] !== want.text_length)
        report_mismatch("text_length", data[9:6], want.text_length);
      if (want.last_char) begin
        numbers_done++;
        lengths_seen[want.text_length] = 1'b1;
      end
    end
    chars_checked++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge, predicts on input
  // transactions, checks on output transactions.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
        if (in_tdata[31]) negatives_sent++;
        values_accepted <= values_accepted + 1;
      end
      if (out_tvalid && out_tready) check_char(out_tdata, out_tlast);
    end
  end

  // Watchdog: only cycles with no transaction on either side count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sender: holds a value until its transaction, then idles or offers the next.
  always @(negedge clk) begin
    logic go;
    go = quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_values.size() != 0 && go) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_values.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off while the
  // sender keeps offering, so the pipeline fills and in_tready drops.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!hold_done && values_accepted >= HOLD_OFF_AT) begin
        out_tready <= 1'b0;
        hold_left  <= HOLD_OFF_LEN - 1;
        hold_done  <= 1'b1;
      end else begin
        out_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // zero, single digits, values next to powers of ten, both extremes, alternating bits
    pending_values = '{32'd0, 32'd1, -32'sd1, 32'd5, 32'd9, -32'sd9, 32'd10, -32'sd10,
                       32'd99, -32'sd99, 32'd100, 32'd12345, -32'sd67890,
                       32'd999999999, -32'sd999999999, 32'd1000000000, -32'sd1000000000,
                       32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                       32'h5555_5555, 32'hAAAA_AAAA};
    for (int i = 0; i < RANDOM_VALUES; i++) pending_values.push_back(random_value());

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_values.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0)
      report_mismatch("characters never delivered", 0, expected_chars.size());

    $display("Formatted %0d values (%0d negative) into %0d checked characters",
             numbers_done, negatives_sent, chars_checked);
    $display("Text lengths seen (bit n = length n): %b, with a %0d-cycle receiver stall",
             lengths_seen, HOLD_OFF_LEN);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
